FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// cond holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed");
// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/btab_pkg.sv
// ---------------------------------------------------------------------------
// btab_pkg
// Types and codes for the breakpoint table engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package btab_pkg;

  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_DELETE  = 3'd1;
  localparam logic [2:0] ACT_ENABLE  = 3'd2;
  localparam logic [2:0] ACT_DISABLE = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_SAME    = 3'd4;

  localparam logic [7:0] TRAP_BYTE = 8'hcc;
  localparam int         TOTAL_W   = 5;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] address;
    logic [31:0] bp_id;
    logic [7:0]  prior_byte;
  } bp_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        result_id;
    logic               mem_write;
    logic [63:0]        mem_address;
    logic [7:0]         mem_byte;
    logic               found_enabled;
    logic [7:0]         found_saved_byte;
    logic [TOTAL_W-1:0] entry_total;
  } bp_out_t;

  // one table slot as stored in the memory
  typedef struct packed {
    logic [63:0] address;
    logic [31:0] ident;
    logic [7:0]  saved_byte;
    logic        enabled;
  } bp_entry_t;

endpackage

FILE: src/btab_ram.sv
// ---------------------------------------------------------------------------
// btab_ram
// Single-port-write, single-port-read slot memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btab_ram
  import btab_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  bp_entry_t        wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output bp_entry_t        rd_data
);

  bp_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/breakpoint_table_engine_unit.sv
// ---------------------------------------------------------------------------
// breakpoint_table_engine_unit
// Ordered software breakpoint table: add, delete with compaction, enable,
// disable and query, one transaction at a time over a slot memory.
// ---------------------------------------------------------------------------
// Order of work: each lookup or add reads the slots in order and answers at the
//   first hit; a miss or an add answers after the last entry, a delete that hits
//   first moves the slots above down, and an unknown action or a full add answers without a scan.
// busy drops with out_valid, so a new transaction is taken only after the last result.
// Reset: clears entry count, id counter and control; slot contents are kept.
// out_valid marks each result for exactly one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module breakpoint_table_engine_unit
  import btab_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  bp_in_t  in_item,
  output logic    out_valid,
  output bp_out_t out_result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TOT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t           state_r, state_nxt;
  bp_in_t           req_r, req_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      last_id_r, last_id_nxt;
  bp_out_t          res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  bp_entry_t        rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  bp_entry_t        wr_data;

  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic [TOT_W-1:0] tot_now;
  logic [TOT_W-1:0] tot_inc;
  logic [TOT_W-1:0] tot_dec;
  logic             act_known;
  logic             key_is_addr;
  logic             hit;
  logic             want_en;
  logic [31:0]      next_id;
  bp_out_t          blank;

  btab_ram #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign count_inc   = count_r + 1'b1;
  assign count_dec   = count_r - 1'b1;
  assign tot_now     = TOT_W'(count_r);
  assign tot_inc     = TOT_W'(count_inc);
  assign tot_dec     = TOT_W'(count_dec);
  assign next_id     = last_id_r + 32'd1;
  assign act_known   = (req_r.action == ACT_ADD) || (req_r.action == ACT_DELETE) ||
                       (req_r.action == ACT_ENABLE) || (req_r.action == ACT_DISABLE) ||
                       (req_r.action == ACT_QUERY);
  assign key_is_addr = (req_r.action == ACT_ADD) || (req_r.action == ACT_QUERY);
  assign hit         = key_is_addr ? (rd_data.address == req_r.address)
                                   : (rd_data.ident == req_r.bp_id);
  assign want_en     = (req_r.action == ACT_ENABLE);

  always_comb begin
    blank             = '0;
    blank.status      = ST_MISSING;
    blank.entry_total = tot_now[TOTAL_W-1:0];

    state_nxt     = state_r;
    req_nxt       = req_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    count_nxt     = count_r;
    last_id_nxt   = last_id_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;

    rd_en   = 1'b0;
    rd_addr = ptr_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = rd_idx_r;
    wr_data = rd_data;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          ptr_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (!act_known) begin
          res_nxt       = blank;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if ((req_r.action == ACT_ADD) && (count_r >= DEPTH_C)) begin
          res_nxt        = blank;
          res_nxt.status = ST_FULL;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (pend_r && hit) begin
          res_nxt = blank;
          case (req_r.action)
            ACT_ADD: begin
              res_nxt.status = ST_DUP;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end
            ACT_QUERY: begin
              res_nxt.status           = ST_OK;
              res_nxt.result_id        = rd_data.ident;
              res_nxt.found_enabled    = rd_data.enabled;
              res_nxt.found_saved_byte = rd_data.saved_byte;
              out_valid_nxt            = 1'b1;
              state_nxt                = S_IDLE;
            end
            ACT_DELETE: begin
              // result goes out once the slots above are moved down
              res_nxt.status      = ST_OK;
              res_nxt.mem_write   = 1'b1;
              res_nxt.mem_address = rd_data.address;
              res_nxt.mem_byte    = rd_data.saved_byte;
              ptr_nxt             = CNT_W'(rd_idx_r) + 1'b1;
              state_nxt           = S_SHIFT;
            end
            default: begin
              if (rd_data.enabled == want_en) begin
                res_nxt.status = ST_SAME;
              end else begin
                wr_en               = 1'b1;
                wr_addr             = rd_idx_r;
                wr_data             = rd_data;
                wr_data.enabled     = want_en;
                res_nxt.status      = ST_OK;
                res_nxt.mem_write   = 1'b1;
                res_nxt.mem_address = rd_data.address;
                res_nxt.mem_byte    = want_en ? TRAP_BYTE : rd_data.saved_byte;
              end
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          endcase
        end else if (ptr_r < count_r) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + 1'b1;
        end else begin
          res_nxt = blank;
          if (req_r.action == ACT_ADD) begin
            // append under the next id
            wr_en              = 1'b1;
            wr_addr            = count_r[IDX_W-1:0];
            wr_data.address    = req_r.address;
            wr_data.ident      = next_id;
            wr_data.saved_byte = req_r.prior_byte;
            wr_data.enabled    = 1'b1;
            last_id_nxt         = next_id;
            count_nxt           = count_inc;
            res_nxt.status      = ST_OK;
            res_nxt.result_id   = next_id;
            res_nxt.mem_write   = 1'b1;
            res_nxt.mem_address = req_r.address;
            res_nxt.mem_byte    = TRAP_BYTE;
            res_nxt.entry_total = tot_inc[TOTAL_W-1:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_SHIFT: begin
        // drop the slot read last cycle one place down
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_r - 1'b1;
          wr_data = rd_data;
        end
        if (ptr_r < count_r) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + 1'b1;
        end else begin
          count_nxt           = count_dec;
          res_nxt.entry_total = tot_dec[TOTAL_W-1:0];
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      count_r     <= '0;
      last_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      last_id_r   <= last_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r    <= req_nxt;
    ptr_r    <= ptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    res_r    <= res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= DEPTH_C)
  `ASSERT_ALWAYS(a_no_write_idle, clk, rst_n, !(wr_en && (state_r == S_IDLE)))
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r)

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the breakpoint table engine. A directed sequence
// covers the empty table, duplicate adds, enable/disable with and without a
// change, delete of a disabled entry, compaction and unknown actions. Random
// traffic then cycles the table between empty and full. Each result is
// checked against a shadow table kept by the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import btab_pkg::*;

  localparam int TABLE_SLOTS  = 16;
  localparam int RANDOM_ITEMS = 225;  // per idling phase, four phases
  localparam int SETTLE_CYC   = 60;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  bp_in_t  in_item = '0;
  logic    out_valid;
  bp_out_t out_result;

  breakpoint_table_engine_unit #(
    .TABLE_DEPTH(TABLE_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow of the breakpoint table
  bp_entry_t   shadow_tab [TABLE_SLOTS];
  int          shadow_total = 0;
  logic [31:0] shadow_last_id = '0;
  bit          filling = 1'b1;

  bp_in_t  cmd_queue[$];
  bp_out_t expected_replies[$];
  int      sent_cnt = 0;
  int      acc_cnt = 0;
  int      fails = 0;
  int      idle_pct = 0;

  function automatic int find_by_address(logic [63:0] a);
    for (int i = 0; i < shadow_total; i++)
      if (shadow_tab[i].address == a) return i;
    return -1;
  endfunction

  function automatic int find_by_ident(logic [31:0] id);
    for (int i = 0; i < shadow_total; i++)
      if (shadow_tab[i].ident == id) return i;
    return -1;
  endfunction

  // update the shadow table and return the reply the engine owes
  function automatic bp_out_t apply_command(bp_in_t cmd);
    bp_out_t r;
    int      k;
    logic    want;
    r = '0;
    r.status = ST_MISSING;
    case (cmd.action)
      ACT_ADD: begin
        if (shadow_total >= TABLE_SLOTS) begin
          r.status = ST_FULL;
        end else if (find_by_address(cmd.address) >= 0) begin
          r.status = ST_DUP;
        end else begin
          shadow_last_id = shadow_last_id + 32'd1;
          shadow_tab[shadow_total].address    = cmd.address;
          shadow_tab[shadow_total].ident      = shadow_last_id;
          shadow_tab[shadow_total].saved_byte = cmd.prior_byte;
          shadow_tab[shadow_total].enabled    = 1'b1;
          shadow_total++;
          r.status      = ST_OK;
          r.result_id   = shadow_last_id;
          r.mem_write   = 1'b1;
          r.mem_address = cmd.address;
          r.mem_byte    = TRAP_BYTE;
        end
      end
      ACT_DELETE: begin
        k = find_by_ident(cmd.bp_id);
        if (k >= 0) begin
          r.status      = ST_OK;
          r.mem_write   = 1'b1;
          r.mem_address = shadow_tab[k].address;
          r.mem_byte    = shadow_tab[k].saved_byte;
          // close the gap, keep order
          for (int i = k; i + 1 < shadow_total; i++)
            shadow_tab[i] = shadow_tab[i + 1];
          shadow_total--;
        end
      end
      ACT_ENABLE, ACT_DISABLE: begin
        k = find_by_ident(cmd.bp_id);
        want = (cmd.action == ACT_ENABLE);
        if (k >= 0) begin
          if (shadow_tab[k].enabled == want) begin
            r.status = ST_SAME;
          end else begin
            r.status      = ST_OK;
            r.mem_write   = 1'b1;
            r.mem_address = shadow_tab[k].address;
            r.mem_byte    = want ? TRAP_BYTE : shadow_tab[k].saved_byte;
            shadow_tab[k].enabled = want;
          end
        end
      end
      ACT_QUERY: begin
        k = find_by_address(cmd.address);
        if (k >= 0) begin
          r.status           = ST_OK;
          r.result_id        = shadow_tab[k].ident;
          r.found_enabled    = shadow_tab[k].enabled;
          r.found_saved_byte = shadow_tab[k].saved_byte;
        end
      end
      default: begin
      end
    endcase
    r.entry_total = TOTAL_W'(shadow_total);
    return r;
  endfunction

  // mostly well-formed commands against live entries, some noise
  function automatic bp_in_t pick_command();
    bp_in_t c;
    int     r;
    int     add_weight;
    if (shadow_total >= TABLE_SLOTS) filling = 1'b0;
    if (shadow_total == 0) filling = 1'b1;
    add_weight = filling ? 55 : 18;

    c.prior_byte = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (shadow_total > 0 && r < 60) begin
      c.address = shadow_tab[$urandom_range(shadow_total - 1)].address;
    end else if (r < 70) begin
      c.address = $urandom_range(1) ? '1 : '0;
    end else begin
      c.address = {$urandom, $urandom};
    end

    r = $urandom_range(99);
    if (shadow_total > 0 && r < 80) begin
      c.bp_id = shadow_tab[$urandom_range(shadow_total - 1)].ident;
    end else if (r < 88) begin
      c.bp_id = shadow_last_id + 32'd1;
    end else begin
      c.bp_id = $urandom;
    end

    r = $urandom_range(99);
    if (r < 3) begin
      c.action = 3'($urandom_range(7, 5));
    end else if (r < 3 + add_weight) begin
      c.action = ACT_ADD;
    end else begin
      case ($urandom_range(filling ? 3 : 5))
        0:       c.action = ACT_ENABLE;
        1:       c.action = ACT_DISABLE;
        2:       c.action = ACT_QUERY;
        default: c.action = ACT_DELETE;
      endcase
    end
    return c;
  endfunction

  task automatic push_cmd(logic [2:0] act, logic [63:0] addr, logic [31:0] id,
                          logic [7:0] orig);
    bp_in_t c;
    c.action     = act;
    c.address    = addr;
    c.bp_id      = id;
    c.prior_byte = orig;
    cmd_queue.push_back(c);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_queue.size() != 0 || acc_cnt != sent_cnt ||
               expected_replies.size() != 0);
  endtask

  task automatic check_reply(bp_out_t exp, bp_out_t act);
    if (act.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, act.status);
      fails++;
    end
    if (act.result_id !== exp.result_id) begin
      $error("result_id: expected %0h, got %0h", exp.result_id, act.result_id);
      fails++;
    end
    if (act.mem_write !== exp.mem_write) begin
      $error("mem_write: expected %0b, got %0b", exp.mem_write, act.mem_write);
      fails++;
    end
    if (act.mem_address !== exp.mem_address) begin
      $error("mem_address: expected %0h, got %0h", exp.mem_address, act.mem_address);
      fails++;
    end
    if (act.mem_byte !== exp.mem_byte) begin
      $error("mem_byte: expected %0h, got %0h", exp.mem_byte, act.mem_byte);
      fails++;
    end
    if (act.found_enabled !== exp.found_enabled) begin
      $error("found_enabled: expected %0b, got %0b", exp.found_enabled,
             act.found_enabled);
      fails++;
    end
    if (act.found_saved_byte !== exp.found_saved_byte) begin
      $error("found_saved_byte: expected %0h, got %0h", exp.found_saved_byte,
             act.found_saved_byte);
      fails++;
    end
    if (act.entry_total !== exp.entry_total) begin
      $error("entry_total: expected %0d, got %0d", exp.entry_total,
             act.entry_total);
      fails++;
    end
  endtask

  // driver: present the next transaction once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || acc_cnt == sent_cnt) begin
      if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= cmd_queue.pop_front();
        start   <= 1'b1;
        sent_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the reply first, then record a newly accepted command
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result: status %0d", out_result.status);
          fails++;
        end else begin
          check_reply(expected_replies.pop_front(), out_result);
        end
      end
      if (start && !busy) begin
        expected_replies.push_back(apply_command(in_item));
        acc_cnt++;
      end
    end
  end

  initial begin
    int phase_idle [4];
    phase_idle = '{0, 49, 0, 13};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: every lookup misses
    push_cmd(ACT_QUERY,   64'd0, 32'd0, 8'h00);
    push_cmd(ACT_DELETE,  64'd0, 32'd1, 8'h00);
    push_cmd(ACT_ENABLE,  '1,    32'd0, 8'hff);
    push_cmd(ACT_DISABLE, '1,    '1,    8'hff);
    // extremes of address and byte, then a duplicate
    push_cmd(ACT_ADD,     64'd0, '1,    8'h00);
    push_cmd(ACT_ADD,     '1,    32'd0, 8'hff);
    push_cmd(ACT_ADD,     64'd0, 32'd7, 8'h5a);
    push_cmd(ACT_QUERY,   '1,    32'd0, 8'h00);
    push_cmd(ACT_QUERY,   64'd0, 32'd0, 8'h00);
    // enable/disable with and without a change
    push_cmd(ACT_ENABLE,  64'd0, 32'd1, 8'h00);
    push_cmd(ACT_DISABLE, 64'd0, 32'd1, 8'h00);
    push_cmd(ACT_DISABLE, 64'd0, 32'd1, 8'h00);
    push_cmd(ACT_QUERY,   64'd0, 32'd0, 8'h00);
    push_cmd(ACT_ENABLE,  64'd0, 32'd1, 8'h00);
    // delete of a disabled entry still restores the byte
    push_cmd(ACT_DISABLE, 64'd0, 32'd2, 8'h00);
    push_cmd(ACT_DELETE,  64'd0, 32'd2, 8'h00);
    push_cmd(ACT_DELETE,  64'd0, 32'd2, 8'h00);
    // unknown actions
    push_cmd(3'd5, {$urandom, $urandom}, $urandom, 8'($urandom_range(255)));
    push_cmd(3'd6, '1, '1, 8'hff);
    push_cmd(3'd7, 64'd0, 32'd1, 8'h00);
    // compaction: delete the head, then find the moved entry
    push_cmd(ACT_ADD,     64'h8000_0000_0000_0001, 32'd0, 8'ha5);
    push_cmd(ACT_DELETE,  64'd0, 32'd1, 8'h00);
    push_cmd(ACT_QUERY,   64'h8000_0000_0000_0001, 32'd0, 8'h00);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        while (cmd_queue.size() != 0) begin
          @(posedge clk);
          #1;
        end
        cmd_queue.push_back(pick_command());
      end
      // hold the sender until every reply is back
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (fails == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/btab_pkg.sv
src/btab_ram.sv
src/breakpoint_table_engine_unit.sv
tb/tb_top.sv
